// ----- hw/rtl/dtec_pkg.sv -----
// ----------------------------------------------------------------------------
// dtec_pkg: shared types and constants for the datetime epoch compare block
// Calendar field bundle, fixed widths, conversion constants and the
// days-before-month table.
// ----------------------------------------------------------------------------
package dtec_pkg;

	localparam int SecsW = 37;
	localparam int DiffW = 47;
	localparam int DaysW = 20;
	localparam int HmsW  = 17;

	localparam int BaseYear        = 1900;
	localparam int DaysPerYear     = 365;
	localparam int SecsPerDay      = 86400;
	localparam int SecsPerHour     = 3600;
	localparam int SecsPerMinute   = 60;
	localparam int MsPerSec        = 1000;
	// leap years in [1, 1899]: 474 - 18 + 4
	localparam int LeapsBeforeBase = 460;
	// floor(x / 25) == (x * Recip25) >> Recip25Shift for x below 1024
	localparam int Recip25         = 1311;
	localparam int Recip25Shift    = 15;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} datetime_t;

	// Days in the whole months before the given month. Month zero counts
	// nothing, any month past December counts the whole year.
	function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] month);
		logic [8:0] base;
		case (month)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd365;
		endcase
		return base + {8'd0, leap && (month >= 4'd3)};
	endfunction

endpackage

// ----- hw/rtl/dtec_secs_pipe.sv -----
// ----------------------------------------------------------------------------
// dtec_secs_pipe: calendar datetime to seconds since 1900-01-01
// Three register stages: year divisions, day count, seconds multiply.
// ----------------------------------------------------------------------------
module dtec_secs_pipe (
	input  logic                            clk,
	input  dtec_pkg::datetime_t             dt,
	output logic [dtec_pkg::SecsW-1:0]      secs
);
	import dtec_pkg::*;

	// stage A: divisions by 4, 100 and 400
	logic [11:0] yr_prev;
	logic [5:0]  q25y;
	logic [5:0]  nq100;
	logic [3:0]  nq400;

	assign yr_prev = dt.year - 12'd1;
	assign q25y    = 6'((21'(dt.year[11:2]) * 21'(Recip25)) >> Recip25Shift);
	assign nq100   = 6'((21'(yr_prev[11:2]) * 21'(Recip25)) >> Recip25Shift);
	assign nq400   = 4'((19'(yr_prev[11:4]) * 19'(Recip25)) >> Recip25Shift);

	logic [9:0]  yq_s2;
	logic [1:0]  ylo_s2;
	logic [5:0]  q25y_s2;
	logic [9:0]  nq4_s2;
	logic [5:0]  nq100_s2;
	logic [3:0]  nq400_s2;
	logic [11:0] years_s2;
	logic        after_s2;
	logic [3:0]  month_s2;
	logic [4:0]  day_s2;
	logic [4:0]  hour_s2;
	logic [5:0]  minute_s2;
	logic [5:0]  second_s2;

	always_ff @(posedge clk) begin
		yq_s2     <= dt.year[11:2];
		ylo_s2    <= dt.year[1:0];
		q25y_s2   <= q25y;
		nq4_s2    <= yr_prev[11:2];
		nq100_s2  <= nq100;
		nq400_s2  <= nq400;
		years_s2  <= dt.year - 12'(BaseYear);
		after_s2  <= dt.year > 12'(BaseYear);
		month_s2  <= dt.month;
		day_s2    <= dt.day;
		hour_s2   <= dt.hour;
		minute_s2 <= dt.minute;
		second_s2 <= dt.second;
	end

	// stage B: leap test, day count, time of day
	logic [9:0]      yrem;
	logic            leap;
	logic [9:0]      leaps;
	logic [DaysW-1:0] year_days;
	logic [4:0]      day_off;
	logic [DaysW-1:0] days_c;
	logic [HmsW-1:0] hms_c;

	assign yrem  = yq_s2 - 10'(11'(q25y_s2) * 11'd25);
	assign leap  = (ylo_s2 == 2'd0) && ((yrem != 10'd0) || (q25y_s2[1:0] == 2'd0));
	assign leaps = 10'(11'(nq4_s2) - 11'(nq100_s2) + 11'(nq400_s2) - 11'(LeapsBeforeBase));
	assign year_days = after_s2 ?
		DaysW'(DaysW'(years_s2) * DaysW'(DaysPerYear)) + DaysW'(leaps) : '0;
	assign day_off = (day_s2 == 5'd0) ? 5'd0 : day_s2 - 5'd1;
	assign days_c  = year_days + DaysW'(cum_days(leap, month_s2)) + DaysW'(day_off);
	assign hms_c   = HmsW'(HmsW'(hour_s2) * HmsW'(SecsPerHour))
		+ HmsW'(HmsW'(minute_s2) * HmsW'(SecsPerMinute)) + HmsW'(second_s2);

	logic [DaysW-1:0] days_s3;
	logic [HmsW-1:0]  hms_s3;

	always_ff @(posedge clk) begin
		days_s3 <= days_c;
		hms_s3  <= hms_c;
	end

	// stage C: days to seconds
	logic [SecsW-1:0] secs_s4;

	always_ff @(posedge clk) begin
		secs_s4 <= SecsW'(SecsW'(days_s3) * SecsW'(SecsPerDay)) + SecsW'(hms_s3);
	end

	assign secs = secs_s4;

endmodule

// ----- hw/rtl/datetime_epoch_compare.sv -----
// ----------------------------------------------------------------------------
// datetime_epoch_compare: datetime to epoch seconds with reference compare
// Converts a calendar datetime to seconds since 1900-01-01 and compares it,
// to the millisecond, with a reference datetime held in registers.
// ----------------------------------------------------------------------------
// One transfer is taken on every clock edge where start is high; busy stays
// low, so a new datetime may follow in every cycle. Each result appears on
// the result ports for exactly one cycle, marked by done; results come out
// in the order the items went in and the receiver must take them as they
// come. The result passes through five register stages: input capture,
// year divisions by constant reciprocals, day count, days-to-seconds
// multiply, and the difference/compare stage.
// The reference datetime runs through its own copy of the conversion stages,
// so a register write takes effect for a transfer started in the same cycle.
// Write the registers only while no transfer is in flight: the reference
// milliseconds are read at the compare stage while the other reference
// fields enter the conversion stages, so an item already in the pipeline
// would see a mix of old and new reference fields.
// Fields are not checked for calendar validity: month zero counts no months,
// months past December count the whole year, day zero counts no days, and
// years before 1900 count no whole years.
// Registers (APB, byte address 4*i, all reset to 1900-01-01 00:00:00.000):
// ref_year, ref_month, ref_day, ref_hour, ref_minute, ref_second,
// ref_millisecond.
module datetime_epoch_compare (
	input  logic                              clk,
	input  logic                              arst_n,
	// item channel
	input  logic                              start,
	output logic                              busy,
	input  logic [11:0]                       year,
	input  logic [3:0]                        month,
	input  logic [4:0]                        day,
	input  logic [4:0]                        hour,
	input  logic [5:0]                        minute,
	input  logic [5:0]                        second,
	input  logic [9:0]                        millisecond,
	// result channel
	output logic                              done,
	output logic [dtec_pkg::SecsW-1:0]        total_seconds,
	output logic signed [dtec_pkg::DiffW-1:0] diff_ms,
	output logic                              is_less,
	output logic                              is_greater,
	output logic                              is_equal,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [4:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import dtec_pkg::*;

	typedef enum logic [2:0] {
		RegYear   = 3'd0,
		RegMonth  = 3'd1,
		RegDay    = 3'd2,
		RegHour   = 3'd3,
		RegMinute = 3'd4,
		RegSecond = 3'd5,
		RegMs     = 3'd6
	} cfg_reg_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	datetime_t  ref_dt_q;
	logic [9:0] ref_ms_q;
	logic       cfg_wr;
	cfg_reg_t   cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_sel = cfg_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_dt_q.year   <= 12'(BaseYear);
			ref_dt_q.month  <= 4'd1;
			ref_dt_q.day    <= 5'd1;
			ref_dt_q.hour   <= 5'd0;
			ref_dt_q.minute <= 6'd0;
			ref_dt_q.second <= 6'd0;
			ref_ms_q        <= 10'd0;
		end else if (cfg_wr) begin
			case (cfg_sel)
				RegYear:   ref_dt_q.year   <= pwdata[11:0];
				RegMonth:  ref_dt_q.month  <= pwdata[3:0];
				RegDay:    ref_dt_q.day    <= pwdata[4:0];
				RegHour:   ref_dt_q.hour   <= pwdata[4:0];
				RegMinute: ref_dt_q.minute <= pwdata[5:0];
				RegSecond: ref_dt_q.second <= pwdata[5:0];
				RegMs:     ref_ms_q        <= pwdata[9:0];
				default: begin
					// drop writes past the register list
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			RegYear:   prdata = {20'd0, ref_dt_q.year};
			RegMonth:  prdata = {28'd0, ref_dt_q.month};
			RegDay:    prdata = {27'd0, ref_dt_q.day};
			RegHour:   prdata = {27'd0, ref_dt_q.hour};
			RegMinute: prdata = {26'd0, ref_dt_q.minute};
			RegSecond: prdata = {26'd0, ref_dt_q.second};
			RegMs:     prdata = {22'd0, ref_ms_q};
			default:   prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input capture: take a transfer every cycle start is high
	// ------------------------------------------------------------------
	logic       accept;
	datetime_t  in_dt_s1;
	logic [9:0] ms_s1, ms_s2, ms_s3, ms_s4;
	logic       v_s1, v_s2, v_s3, v_s4;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		in_dt_s1 <= '{year: year, month: month, day: day, hour: hour,
			minute: minute, second: second};
		ms_s1 <= millisecond;
		ms_s2 <= ms_s1;
		ms_s3 <= ms_s2;
		ms_s4 <= ms_s3;
	end

	// advance the valid marks alongside the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// Seconds conversion: one lane for the item, one for the reference.
	// The reference registers stand in the place of the input register,
	// so both lanes line up stage for stage.
	// ------------------------------------------------------------------
	logic [SecsW-1:0] in_secs_s4;
	logic [SecsW-1:0] ref_secs_s4;

	dtec_secs_pipe u_in_secs (
		.clk  (clk),
		.dt   (in_dt_s1),
		.secs (in_secs_s4)
	);

	dtec_secs_pipe u_ref_secs (
		.clk  (clk),
		.dt   (ref_dt_q),
		.secs (ref_secs_s4)
	);

	// ------------------------------------------------------------------
	// Difference and compare. The seconds decide first; milliseconds
	// only break a tie, even when they are past 999.
	// ------------------------------------------------------------------
	logic [DiffW-1:0] sec_diff;
	logic [DiffW-1:0] diff_c;
	logic             sec_eq, sec_lt, ms_lt, ms_eq;

	assign sec_diff = DiffW'(in_secs_s4) - DiffW'(ref_secs_s4);
	assign diff_c   = DiffW'(sec_diff * DiffW'(MsPerSec)) + DiffW'(ms_s4) - DiffW'(ref_ms_q);
	assign sec_eq   = in_secs_s4 == ref_secs_s4;
	assign sec_lt   = in_secs_s4 < ref_secs_s4;
	assign ms_eq    = ms_s4 == ref_ms_q;
	assign ms_lt    = ms_s4 < ref_ms_q;

	logic             done_q;
	logic [SecsW-1:0] total_seconds_q;
	logic [DiffW-1:0] diff_ms_q;
	logic             is_less_q, is_greater_q, is_equal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s4;
		end
	end

	// hold the result for its one strobe cycle
	always_ff @(posedge clk) begin
		total_seconds_q <= in_secs_s4;
		diff_ms_q       <= diff_c;
		is_less_q       <= sec_lt || (sec_eq && ms_lt);
		is_greater_q    <= !sec_lt && !sec_eq || (sec_eq && !ms_lt && !ms_eq);
		is_equal_q      <= sec_eq && ms_eq;
	end

	assign done          = done_q;
	assign total_seconds = total_seconds_q;
	assign diff_ms       = signed'(diff_ms_q);
	assign is_less       = is_less_q;
	assign is_greater    = is_greater_q;
	assign is_equal      = is_equal_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("result strobe missing five cycles after a transfer");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 5))
		else $error("result strobe without a matching transfer");

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot({is_less, is_greater, is_equal}))
		else $error("compare flags not exactly one hot");

	a_equal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_equal) |-> (diff_ms == '0))
		else $error("equal flag with nonzero difference");
`endif

endmodule
